// ===== rtl/pi_pkg.sv =====
// Shared constants, types and a helper function of the particle integrator.
`default_nettype none

package pi_pkg;

    localparam int IDX_W         = 10;
    localparam int MAX_PARTICLES = 1 << IDX_W;
    localparam int CW            = 32;
    localparam int DIV_N_W       = 49;
    localparam int DIV_D_W       = 16;
    localparam int DIV_STAGES    = DIV_N_W;

    localparam logic [1:0] METHOD_EXPLICIT = 2'd0;
    localparam logic [1:0] METHOD_SEMI     = 2'd1;
    localparam logic [1:0] METHOD_VERLET   = 2'd2;

    localparam logic [1:0] REG_METHOD    = 2'd0;
    localparam logic [1:0] REG_TIME_STEP = 2'd1;
    localparam logic [1:0] REG_DAMPING   = 2'd2;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             verlet;
        logic             semi;
        logic             pin;
    } pi_ctrl_t;

    typedef struct packed {
        pi_ctrl_t           ctl;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [33:0] c;
    } pi_tag_t;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [63:0] x);
        logic signed [CW-1:0] r;
        begin
            if (x > SAT_HI) begin
                r = SAT_HI[CW-1:0];
            end else if (x < SAT_LO) begin
                r = SAT_LO[CW-1:0];
            end else begin
                r = x[CW-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, carrying a side tag.
`default_nettype none

module pi_div import pi_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               ce,
    input  wire logic [DIV_N_W-1:0] num,
    input  wire logic               num_neg,
    input  wire logic [DIV_D_W-1:0] den,
    input  wire pi_tag_t            tag_in,
    output logic      [DIV_N_W-1:0] quo,
    output logic                    quo_neg,
    output pi_tag_t                 tag_out
);

    typedef struct packed {
        logic [DIV_D_W-1:0] rem;
        logic [DIV_N_W-1:0] nq;
        logic [DIV_D_W-1:0] den;
        logic               neg;
        pi_tag_t            tag;
    } div_st_t;

    div_st_t st_reg [DIV_STAGES];
    div_st_t st_init;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    function automatic div_st_t div_step(input div_st_t s);
        div_st_t          r;
        logic [DIV_D_W:0] t;
        logic [DIV_D_W:0] d;
        begin
            r = s;
            t = {s.rem, s.nq[DIV_N_W-1]};
            d = {1'b0, s.den};
            if (t >= d) begin
                r.rem = DIV_D_W'(t - d);
                r.nq  = {s.nq[DIV_N_W-2:0], 1'b1};
            end else begin
                r.rem = t[DIV_D_W-1:0];
                r.nq  = {s.nq[DIV_N_W-2:0], 1'b0};
            end
            return r;
        end
    endfunction

    always_comb begin
        st_init.rem = '0;
        st_init.nq  = num;
        st_init.den = den;
        st_init.neg = num_neg;
        st_init.tag = tag_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                st_reg[k].tag.ctl.vld <= 1'b0;
            end
        end else if (ce) begin
            st_reg[0] <= div_step(st_init);
            for (int k = 1; k < DIV_STAGES; k++) begin
                st_reg[k] <= div_step(st_reg[k-1]);
            end
        end
    end

    assign quo     = st_reg[DIV_STAGES-1].nq;
    assign quo_neg = st_reg[DIV_STAGES-1].neg;
    assign tag_out = st_reg[DIV_STAGES-1].tag;

endmodule

`default_nettype wire

// ===== rtl/pi_store.sv =====
// Previous-position store for the Verlet scheme, with a clearing pass after reset.
`default_nettype none

module pi_store import pi_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] addr,
    input  wire logic [3*CW-1:0]  wdata,
    output logic      [3*CW-1:0]  rdata,
    output logic                  rd_ok,
    output logic                  busy
);

    logic [3*CW:0] mem [MAX_PARTICLES];
    logic [3*CW:0] rd_reg;
    logic [IDX_W:0] clr_cnt_reg;

    assign busy = !clr_cnt_reg[IDX_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (busy) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Reads see the contents from before a write in the same cycle.
    always_ff @(posedge aclk) begin
        if (busy) begin
            mem[clr_cnt_reg[IDX_W-1:0]] <= '0;
        end else if (wr_en) begin
            mem[addr] <= {1'b1, wdata};
        end
        if (rd_en) begin
            rd_reg <= mem[addr];
        end
    end

    assign rdata = rd_reg[3*CW-1:0];
    assign rd_ok = rd_reg[3*CW];

endmodule

`default_nettype wire

// ===== rtl/pi_axis.sv =====
// Datapath for one coordinate axis: damping, force term, division and final update.
`default_nettype none

module pi_axis import pi_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ce,
    input  wire pi_ctrl_t              in_ctl,
    input  wire logic signed [CW-1:0]  pos,
    input  wire logic signed [CW-1:0]  vel,
    input  wire logic signed [CW-1:0]  force_in,
    input  wire logic        [15:0]    mass,
    input  wire logic signed [CW-1:0]  prev,
    input  wire logic                  prev_ok,
    input  wire logic        [15:0]    time_step,
    input  wire logic        [15:0]    damping,
    output pi_ctrl_t                   ctl_out,
    output logic signed [CW-1:0]       new_pos,
    output logic signed [CW-1:0]       new_vel
);

    pi_ctrl_t c0_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    pi_ctrl_t c7_reg, c8_reg, c9_reg, c10_reg;

    logic signed [CW-1:0] p0_reg, v0_reg, f0_reg;
    logic        [15:0]   m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    logic signed [CW-1:0] p1_reg, v1_reg, f1_reg;
    logic signed [48:0]   dv1_reg;
    logic signed [33:0]   pp1_reg, pp2_reg, pp3_reg, pp4_reg, pp5_reg, pp6_reg;
    logic signed [CW-1:0] p2_reg, v2_reg, p3_reg, v3_reg, p4_reg, v4_reg;
    logic signed [CW-1:0] p5_reg, v5_reg, p6_reg, v6_reg;
    logic signed [41:0]   net2_reg;
    logic signed [59:0]   nt3_reg, w4_reg, m5p_reg;
    logic [DIV_N_W-1:0]   mag6_reg;
    logic                 neg6_reg;

    logic signed [CW-1:0] res7_reg, p7_reg, v7_reg;
    logic signed [48:0]   prod8_reg;
    logic [DIV_N_W-1:0]   mag8_reg, mag9_reg;
    logic                 neg8_reg, neg9_reg;
    logic signed [CW-1:0] p8_reg, res8_reg, a9_reg, b9_reg, p9_reg;
    logic signed [CW-1:0] pos10_reg, vel10_reg;

    logic signed [16:0]   t_s, d_s;
    logic signed [CW-1:0] q_sel;
    logic signed [48:0]   dv_adj;
    logic signed [59:0]   nt_adj, abs6;
    logic signed [42:0]   w_n;
    pi_tag_t              tag1_in, tag1_out, tag2_in, tag2_out;
    logic [DIV_N_W-1:0]   q1, q2;
    logic                 q1_neg, q2_neg;
    logic signed [50:0]   base7, qx7, sum7;
    logic signed [CW-1:0] opnd8;
    logic signed [32:0]   diff8, adiff8;
    logic signed [48:0]   pr_adj;
    logic signed [CW-1:0] pos_e;
    logic signed [49:0]   qv10, sq10;
    logic signed [CW-1:0] vv10;

    assign t_s = $signed({1'b0, time_step});
    assign d_s = $signed({1'b0, damping});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg <= '0; c1_reg <= '0; c2_reg <= '0; c3_reg <= '0;
            c4_reg <= '0; c5_reg <= '0; c6_reg <= '0; c7_reg <= '0;
            c8_reg <= '0; c9_reg <= '0; c10_reg <= '0;
        end else if (ce) begin
            c0_reg  <= in_ctl;
            c1_reg  <= c0_reg;
            c2_reg  <= c1_reg;
            c3_reg  <= c2_reg;
            c4_reg  <= c3_reg;
            c5_reg  <= c4_reg;
            c6_reg  <= c5_reg;
            c7_reg  <= tag1_out.ctl;
            c8_reg  <= c7_reg;
            c9_reg  <= c8_reg;
            c10_reg <= tag2_out.ctl;
        end
    end

    // A first visit uses the current position as the previous one.
    assign q_sel  = prev_ok ? prev : p0_reg;
    assign dv_adj = dv1_reg + (dv1_reg[48] ? 49'sd255 : 49'sd0);
    assign nt_adj = nt3_reg + (nt3_reg[59] ? 60'sd65535 : 60'sd0);
    assign w_n    = $signed(w4_reg[42:0]);
    assign abs6   = m5p_reg[59] ? -m5p_reg : m5p_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p0_reg   <= pos;
            v0_reg   <= vel;
            f0_reg   <= force_in;
            m0_reg   <= (mass == 16'd0) ? 16'd1 : mass;

            p1_reg   <= p0_reg;
            v1_reg   <= v0_reg;
            f1_reg   <= f0_reg;
            m1_reg   <= m0_reg;
            dv1_reg  <= d_s * v0_reg;
            pp1_reg  <= (34'(p0_reg) <<< 1) - 34'(q_sel);

            p2_reg   <= p1_reg;
            v2_reg   <= v1_reg;
            m2_reg   <= m1_reg;
            pp2_reg  <= pp1_reg;
            net2_reg <= 42'(f1_reg) - 42'(dv_adj >>> 8);

            p3_reg   <= p2_reg;
            v3_reg   <= v2_reg;
            m3_reg   <= m2_reg;
            pp3_reg  <= pp2_reg;
            nt3_reg  <= net2_reg * t_s;

            p4_reg   <= p3_reg;
            v4_reg   <= v3_reg;
            m4_reg   <= m3_reg;
            pp4_reg  <= pp3_reg;
            w4_reg   <= c3_reg.verlet ? (nt_adj >>> 16) : nt3_reg;

            p5_reg   <= p4_reg;
            v5_reg   <= v4_reg;
            m5_reg   <= m4_reg;
            pp5_reg  <= pp4_reg;
            m5p_reg  <= c4_reg.verlet ? 60'(w_n * t_s) : w4_reg;

            p6_reg   <= p5_reg;
            v6_reg   <= v5_reg;
            m6_reg   <= m5_reg;
            pp6_reg  <= pp5_reg;
            mag6_reg <= abs6[56:8];
            neg6_reg <= m5p_reg[59];
        end
    end

    always_comb begin
        tag1_in.ctl = c6_reg;
        tag1_in.a   = p6_reg;
        tag1_in.b   = v6_reg;
        tag1_in.c   = pp6_reg;
    end

    pi_div u_div_force (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .num     (mag6_reg),
        .num_neg (neg6_reg),
        .den     (m6_reg),
        .tag_in  (tag1_in),
        .quo     (q1),
        .quo_neg (q1_neg),
        .tag_out (tag1_out)
    );

    assign base7 = tag1_out.ctl.verlet ? 51'($signed(tag1_out.c)) : 51'($signed(tag1_out.b));
    assign qx7   = $signed({2'b00, q1});
    assign sum7  = q1_neg ? (base7 - qx7) : (base7 + qx7);

    assign opnd8  = c7_reg.semi ? res7_reg : v7_reg;
    assign diff8  = 33'(res7_reg) - 33'(p7_reg);
    assign adiff8 = diff8[32] ? -diff8 : diff8;

    assign pr_adj = prod8_reg + (prod8_reg[48] ? 49'sd65535 : 49'sd0);
    assign pos_e  = sat_coord(64'(p8_reg) + 64'(pr_adj >>> 16));

    always_ff @(posedge aclk) begin
        if (ce) begin
            res7_reg  <= sat_coord(64'(sum7));
            p7_reg    <= tag1_out.a;
            v7_reg    <= tag1_out.b;

            prod8_reg <= opnd8 * t_s;
            mag8_reg  <= c7_reg.verlet ? {1'b0, adiff8[31:0], 16'b0} : '0;
            neg8_reg  <= diff8[32];
            p8_reg    <= p7_reg;
            res8_reg  <= res7_reg;

            a9_reg    <= c8_reg.verlet ? res8_reg : pos_e;
            b9_reg    <= res8_reg;
            p9_reg    <= p8_reg;
            mag9_reg  <= mag8_reg;
            neg9_reg  <= neg8_reg;
        end
    end

    always_comb begin
        tag2_in.ctl = c9_reg;
        tag2_in.a   = a9_reg;
        tag2_in.b   = b9_reg;
        tag2_in.c   = 34'(p9_reg);
    end

    pi_div u_div_vel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .num     (mag9_reg),
        .num_neg (neg9_reg),
        .den     (time_step),
        .tag_in  (tag2_in),
        .quo     (q2),
        .quo_neg (q2_neg),
        .tag_out (tag2_out)
    );

    assign qv10 = $signed({1'b0, q2});
    assign sq10 = q2_neg ? -qv10 : qv10;
    assign vv10 = sat_coord(64'(sq10));

    // A pinned particle keeps its position and stops.
    always_ff @(posedge aclk) begin
        if (ce) begin
            if (tag2_out.ctl.pin) begin
                pos10_reg <= tag2_out.c[CW-1:0];
                vel10_reg <= '0;
            end else if (tag2_out.ctl.verlet) begin
                pos10_reg <= tag2_out.a;
                vel10_reg <= (time_step == 16'd0) ? '0 : vv10;
            end else begin
                pos10_reg <= tag2_out.a;
                vel10_reg <= tag2_out.b;
            end
        end
    end

    assign ctl_out = c10_reg;
    assign new_pos = pos10_reg;
    assign new_vel = vel10_reg;

endmodule

`default_nettype wire

// ===== rtl/particle_integrator_step.sv =====
// Top level of the particle integrator: stream ports, register port and output buffering.
//
// One particle enters per clock while s_tready is high, and the depth of its pipeline
// is set by two 49-stage pipelined dividers per axis (one divides the force term
// by mass, the other the Verlet position change by the time step), plus eleven
// arithmetic stages. After reset the previous-position store is cleared one entry
// a cycle, so s_tready stays low until that pass is done. The output register and a
// one-beat skid buffer let the input keep flowing while a result waits on m_tready.
// Registers must be written only while the block is idle; it does not enforce this.
`default_nettype none

module particle_integrator_step import pi_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // particle_index[9:0], position_x/y/z, velocity_x/y/z, force_x/y/z (32 each), mass[15:0]
    input  wire logic [319:0] s_tdata,
    // pinned
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_index[9:0], new_position_x/y/z, new_velocity_x/y/z (32 each)
    output logic      [207:0] m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    logic [1:0]   method_reg;
    logic [15:0]  time_step_reg;
    logic [15:0]  damping_reg;

    logic         out_v_reg, skid_v_reg;
    logic [207:0] out_reg, skid_reg;

    logic         ce, accept, busy, prev_ok;
    logic         in_verlet;
    pi_ctrl_t     in_ctl, ctl_x;
    logic [3*CW-1:0] prev_data;
    logic signed [CW-1:0] np_x, np_y, np_z, nv_x, nv_y, nv_z;
    logic [207:0] pd;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg    <= METHOD_EXPLICIT;
            time_step_reg <= 16'd655;
            damping_reg   <= 16'd0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_METHOD:    method_reg    <= pwdata[1:0];
                REG_TIME_STEP: time_step_reg <= pwdata[15:0];
                REG_DAMPING:   damping_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_METHOD:    prdata = {30'd0, method_reg};
            REG_TIME_STEP: prdata = {16'd0, time_step_reg};
            REG_DAMPING:   prdata = {16'd0, damping_reg};
            default:       prdata = '0;
        endcase
    end

    // The pipeline moves as a whole; it halts only when the skid beat is occupied.
    assign ce        = !skid_v_reg;
    assign s_tready  = ce && !busy;
    assign accept    = s_tvalid && s_tready;
    assign in_verlet = (method_reg == METHOD_VERLET);

    always_comb begin
        in_ctl.vld    = accept;
        in_ctl.idx    = s_tdata[9:0];
        in_ctl.verlet = in_verlet;
        in_ctl.semi   = (method_reg == METHOD_SEMI);
        in_ctl.pin    = s_tuser;
    end

    pi_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .wr_en   (accept && in_verlet && !s_tuser),
        .addr    (s_tdata[9:0]),
        .wdata   (s_tdata[105:10]),
        .rdata   (prev_data),
        .rd_ok   (prev_ok),
        .busy    (busy)
    );

    pi_axis u_axis_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_ctl    (in_ctl),
        .pos       ($signed(s_tdata[41:10])),
        .vel       ($signed(s_tdata[137:106])),
        .force_in  ($signed(s_tdata[233:202])),
        .mass      (s_tdata[313:298]),
        .prev      ($signed(prev_data[31:0])),
        .prev_ok   (prev_ok),
        .time_step (time_step_reg),
        .damping   (damping_reg),
        .ctl_out   (ctl_x),
        .new_pos   (np_x),
        .new_vel   (nv_x)
    );

    pi_axis u_axis_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_ctl    (in_ctl),
        .pos       ($signed(s_tdata[73:42])),
        .vel       ($signed(s_tdata[169:138])),
        .force_in  ($signed(s_tdata[265:234])),
        .mass      (s_tdata[313:298]),
        .prev      ($signed(prev_data[63:32])),
        .prev_ok   (prev_ok),
        .time_step (time_step_reg),
        .damping   (damping_reg),
        .ctl_out   (),
        .new_pos   (np_y),
        .new_vel   (nv_y)
    );

    pi_axis u_axis_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_ctl    (in_ctl),
        .pos       ($signed(s_tdata[105:74])),
        .vel       ($signed(s_tdata[201:170])),
        .force_in  ($signed(s_tdata[297:266])),
        .mass      (s_tdata[313:298]),
        .prev      ($signed(prev_data[95:64])),
        .prev_ok   (prev_ok),
        .time_step (time_step_reg),
        .damping   (damping_reg),
        .ctl_out   (),
        .new_pos   (np_z),
        .new_vel   (nv_z)
    );

    assign pd = {6'd0, nv_z, nv_y, nv_x, np_z, np_y, np_x, ctl_x.idx};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (ce) begin
            if (ctl_x.vld) begin
                if (out_v_reg && !m_tready) begin
                    skid_v_reg <= 1'b1;
                end else begin
                    out_v_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end else if (m_tready) begin
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (ctl_x.vld) begin
                if (out_v_reg && !m_tready) begin
                    skid_reg <= pd;
                end else begin
                    out_reg <= pd;
                end
            end
        end else if (m_tready) begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire
